>>> src/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types, constants and tables for the line phase ramp rotator.
// ----------------------------------------------------------------------------
package lpr_pkg;

	// sample and working formats
	localparam int SAMPLE_WIDTH = 24;
	localparam int CORDIC_GUARD = 8;
	localparam int WORK_W       = SAMPLE_WIDTH + CORDIC_GUARD + 2;
	localparam int Z_W          = 34;
	localparam int MUL_W        = SAMPLE_WIDTH + 32;
	localparam int PRE_SH       = 31 - CORDIC_GUARD;
	localparam int REG_W        = 11;
	localparam int OFF_W        = 14;

	// defaults for the top level parameters
	localparam int MAX_ROW_DEF     = 1024;
	localparam int MAX_LINES_DEF   = 1024;
	localparam int ANGLE_WIDTH_DEF = 32;

	// 1/K of the cordic gain in Q31
	localparam logic [31:0] KINV_Q31 = 32'd1304065748;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_ROW_LENGTH     = 1'b0,
		CFG_RAW_LINE_COUNT = 1'b1
	} cfg_idx_t;

	// input beat
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample_re;
		logic signed [SAMPLE_WIDTH-1:0] sample_im;
		logic        [9:0]              column;
		logic        [9:0]              line_index;
		logic signed [31:0]             lin_coef;
		logic signed [31:0]             const_coef;
		logic                           last_in;
	} line_in_t;

	// result beat
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] out_re;
		logic signed [SAMPLE_WIDTH-1:0] out_im;
		logic                           last_out;
	} line_out_t;

	// one cordic stage
	typedef struct packed {
		logic signed [WORK_W-1:0]       x;
		logic signed [WORK_W-1:0]       y;
		logic signed [Z_W-1:0]          z;
		logic signed [SAMPLE_WIDTH-1:0] raw_re;
		logic signed [SAMPLE_WIDTH-1:0] raw_im;
		logic                           corr;
		logic                           last;
	} cord_t;

endpackage

>>> src/line_phase_ramp_rotator.sv
// ----------------------------------------------------------------------------
// line_phase_ramp_rotator
// Rotates each k-space sample by a per-line linear phase ramp via a pipelined
// cordic, lines at or beyond raw_line_count (capped at MAX_LINES) pass through unchanged.
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  input     start, busy, sample_in             beat taken when start & !busy
//  result    done, result                       one cycle strobe, no backpressure
//  config    cfg_we, cfg_index, cfg_wdata       write when cfg_we high
//
//  one beat enters every cycle; busy stays low
//  the pipeline has three stages for offset, the angle and
//  scaling multipliers and the fold, one cordic stage per micro-rotation, one
//  output stage for rounding and saturation
//  reset clears the valid bits and loads both registers with 256
// ----------------------------------------------------------------------------
module line_phase_ramp_rotator
	import lpr_pkg::*;
#(
	parameter int MAX_ROW     = MAX_ROW_DEF,
	parameter int MAX_LINES   = MAX_LINES_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  line_in_t         sample_in,
	output logic             done,
	output line_out_t        result,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [REG_W-1:0] cfg_wdata
);

	localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_WIDTH)) - 32'd1);
	localparam logic [12:0] ROW_CAP  = 13'(MAX_ROW);
	localparam logic [12:0] LINE_CAP = 13'(MAX_LINES);
	localparam logic signed [WORK_W-1:0] SAT_HI =
		WORK_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [WORK_W-1:0] SAT_LO = -SAT_HI - WORK_W'(1);

	// configuration registers
	logic [REG_W-1:0] row_length_q;
	logic [REG_W-1:0] raw_line_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q     <= REG_W'(256);
			raw_line_count_q <= REG_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROW_LENGTH:     row_length_q     <= cfg_wdata;
				CFG_RAW_LINE_COUNT: raw_line_count_q <= cfg_wdata;
				default:            ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: column offset and line select
	logic [12:0]             rl_eff;
	logic [12:0]             lines_eff;
	logic signed [OFF_W-1:0] off_c;

	always_comb begin
		rl_eff    = ({2'b00, row_length_q} > ROW_CAP) ? ROW_CAP : {2'b00, row_length_q};
		lines_eff = ({2'b00, raw_line_count_q} > LINE_CAP) ? LINE_CAP
			: {2'b00, raw_line_count_q};
		off_c     = $signed({4'b0000, sample_in.column}) - $signed({2'b00, rl_eff[12:1]});
	end

	line_in_t                in_s1;
	logic signed [OFF_W-1:0] off_s1;
	logic                    corr_s1;
	logic                    vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		in_s1   <= sample_in;
		off_s1  <= off_c;
		corr_s1 <= ({3'b000, sample_in.line_index} < lines_eff);
	end

	// stage 2: phase product and input pre-scale
	logic signed [OFF_W+31:0]       ang_prod_c;
	logic signed [MUL_W-1:0]        xp_c;
	logic signed [MUL_W-1:0]        yp_c;

	always_comb begin
		ang_prod_c = off_s1 * in_s1.lin_coef;
		xp_c       = in_s1.sample_re * $signed({1'b0, KINV_Q31[30:0]});
		yp_c       = in_s1.sample_im * $signed({1'b0, KINV_Q31[30:0]});
	end

	logic [31:0]                    prod_s2;
	logic signed [31:0]             cst_s2;
	logic signed [MUL_W-1:0]        xp_s2;
	logic signed [MUL_W-1:0]        yp_s2;
	logic signed [SAMPLE_WIDTH-1:0] re_s2;
	logic signed [SAMPLE_WIDTH-1:0] im_s2;
	logic                           corr_s2;
	logic                           last_s2;
	logic                           vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ang_prod_c[31:0];
		cst_s2  <= in_s1.const_coef;
		xp_s2   <= xp_c;
		yp_s2   <= yp_c;
		re_s2   <= in_s1.sample_re;
		im_s2   <= in_s1.sample_im;
		corr_s2 <= corr_s1;
		last_s2 <= in_s1.last_in;
	end

	// stage 3: angle sum, rounding of the scaled sample, half turn fold
	logic [31:0]              ang_c;
	logic [31:0]              qtr_c;
	logic signed [MUL_W-1:0]  xr_c;
	logic signed [MUL_W-1:0]  yr_c;
	logic signed [WORK_W-1:0] x0_c;
	logic signed [WORK_W-1:0] y0_c;
	cord_t                    fold_c;

	always_comb begin
		ang_c = (prod_s2 + cst_s2) & ANG_MASK;
		qtr_c = ang_c + 32'h4000_0000;
		xr_c  = (xp_s2 + (MUL_W'(1) <<< (PRE_SH - 1))) >>> PRE_SH;
		yr_c  = (yp_s2 + (MUL_W'(1) <<< (PRE_SH - 1))) >>> PRE_SH;
		x0_c  = xr_c[WORK_W-1:0];
		y0_c  = yr_c[WORK_W-1:0];
		fold_c.raw_re = re_s2;
		fold_c.raw_im = im_s2;
		fold_c.corr   = corr_s2;
		fold_c.last   = last_s2;
		if (qtr_c[31]) begin
			fold_c.x = -x0_c;
			fold_c.y = -y0_c;
			fold_c.z = Z_W'($signed({~ang_c[31], ang_c[30:0]}));
		end else begin
			fold_c.x = x0_c;
			fold_c.y = y0_c;
			fold_c.z = Z_W'($signed(ang_c));
		end
	end

	// cordic chain, one micro-rotation per stage
	cord_t cord_s  [ANGLE_WIDTH+1];
	logic  vld_s   [ANGLE_WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		cord_s[0] <= fold_c;
	end

	for (genvar i = 0; i < ANGLE_WIDTH; i++) begin : g_rot
		logic signed [WORK_W-1:0] xs;
		logic signed [WORK_W-1:0] ys;
		logic signed [Z_W-1:0]    at;
		cord_t                    nxt;

		always_comb begin
			xs  = cord_s[i].x >>> i;
			ys  = cord_s[i].y >>> i;
			at  = $signed({{(Z_W-32){1'b0}}, ATAN_TAB[i]});
			nxt = cord_s[i];
			if (!cord_s[i].z[Z_W-1]) begin
				nxt.x = cord_s[i].x - ys;
				nxt.y = cord_s[i].y + xs;
				nxt.z = cord_s[i].z - at;
			end else begin
				nxt.x = cord_s[i].x + ys;
				nxt.y = cord_s[i].y - xs;
				nxt.z = cord_s[i].z + at;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			cord_s[i+1] <= nxt;
		end
	end

	// output stage: round off guard bits, saturate, bypass uncorrected lines
	cord_t                    fin;
	logic signed [WORK_W-1:0] xo_c;
	logic signed [WORK_W-1:0] yo_c;
	line_out_t                res_c;

	always_comb begin
		fin  = cord_s[ANGLE_WIDTH];
		xo_c = (fin.x + (WORK_W'(1) <<< (CORDIC_GUARD - 1))) >>> CORDIC_GUARD;
		yo_c = (fin.y + (WORK_W'(1) <<< (CORDIC_GUARD - 1))) >>> CORDIC_GUARD;
		res_c.last_out = fin.last;
		if (!fin.corr) begin
			res_c.out_re = fin.raw_re;
			res_c.out_im = fin.raw_im;
		end else begin
			priority if (xo_c > SAT_HI) res_c.out_re = SAT_HI[SAMPLE_WIDTH-1:0];
			else if (xo_c < SAT_LO)     res_c.out_re = SAT_LO[SAMPLE_WIDTH-1:0];
			else                        res_c.out_re = xo_c[SAMPLE_WIDTH-1:0];
			priority if (yo_c > SAT_HI) res_c.out_im = SAT_HI[SAMPLE_WIDTH-1:0];
			else if (yo_c < SAT_LO)     res_c.out_im = SAT_LO[SAMPLE_WIDTH-1:0];
			else                        res_c.out_im = yo_c[SAMPLE_WIDTH-1:0];
		end
	end

	line_out_t result_q;
	logic      done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[ANGLE_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
